>>> rtl/fcd_pkg.sv
// Shared types, constants and the sine table generator for the CFO derotator.
// No dependencies; imported by every module of the block.
package fcd_pkg;

   // default parameter values
   localparam int unsigned SAMPLE_WIDTH_DEF     = 16;
   localparam int unsigned PHASE_WIDTH_DEF      = 32;
   localparam int unsigned TABLE_ADDR_WIDTH_DEF = 10;
   localparam int unsigned QUEUE_DEPTH_DEF      = 4;

   // register file
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned GAIN_W     = 16;
   localparam int unsigned COUNT_W    = 16;
   localparam int unsigned TABLE_W    = 15;   // quarter sine magnitude, Q1.15 without sign

   localparam logic [GAIN_W-1:0]  GAIN_RESET      = 16'd16384;
   localparam logic [COUNT_W-1:0] FRAME_LEN_RESET = 16'd1024;
   localparam logic [COUNT_W-1:0] COUNT_MAX       = 16'hFFFF;

   typedef enum logic [1:0] {
      CSR_PHASE_STEP   = 2'd0,
      CSR_START_PHASE  = 2'd1,
      CSR_GAIN         = 2'd2,
      CSR_FRAME_LENGTH = 2'd3
   } fcd_csr_index_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fcd_queue_status_type;

   typedef struct packed {
      logic pop;   // head of queue taken by the datapath
      logic adv;   // datapath pipeline advancing this cycle
   } fcd_back_status_type;

   // pi/2 in Q30 and the Taylor denominators (2n)(2n+1)
   localparam longint unsigned HalfPiQ30 = 64'd1686629713;
   localparam longint unsigned TaylorDiv [10] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420
   };

   // Quarter-wave sine entry k of a table with 2^taw entries per turn.
   // Only ever called with constant arguments (table build at elaboration).
   function automatic logic [TABLE_W-1:0] quarter_sine(input int unsigned taw,
                                                       input int unsigned k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint          r;
      x    = (longint'(k) * HalfPiQ30) >> (taw - 2);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 10; n++) begin
         term = ((term * x2) >> 30) / TaylorDiv[n-1];
         if ((n % 2) == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      r = (sum + 64'sd16384) >>> 15;
      if (r > 64'sd32767) begin
         r = 64'sd32767;
      end
      return r[TABLE_W-1:0];
   endfunction

endpackage

>>> rtl/fcd_sine_rom.sv
// Quarter-wave sine ROM with two registered read ports.
// Depends on fcd_pkg (quarter_sine table generator).
module fcd_sine_rom #(
   parameter int unsigned TABLE_ADDR_WIDTH = fcd_pkg::TABLE_ADDR_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic [TABLE_ADDR_WIDTH-2:0]       addr_a,
   input  logic [TABLE_ADDR_WIDTH-2:0]       addr_b,
   output logic [fcd_pkg::TABLE_W-1:0]       data_a,
   output logic [fcd_pkg::TABLE_W-1:0]       data_b
);
   import fcd_pkg::*;

   localparam int unsigned RomDepth = (1 << (TABLE_ADDR_WIDTH - 2)) + 1;

   logic [TABLE_W-1:0] rom [RomDepth];
   logic [TABLE_W-1:0] data_a_ff;
   logic [TABLE_W-1:0] data_b_ff;

   for (genvar k = 0; k < RomDepth; k++) begin : g_entry
      localparam logic [TABLE_W-1:0] EntryValue = quarter_sine(TABLE_ADDR_WIDTH, k);
      assign rom[k] = EntryValue;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_a_ff <= rom[addr_a];
         data_b_ff <= rom[addr_b];
      end
   end

   assign data_a = data_a_ff;
   assign data_b = data_b_ff;

endmodule

>>> rtl/fcd_front.sv
// Front end: accepts samples, runs the phase accumulator and frame counter.
// Depends on fcd_pkg; feeds fcd_queue.
module fcd_front #(
   parameter int unsigned SAMPLE_WIDTH     = fcd_pkg::SAMPLE_WIDTH_DEF,
   parameter int unsigned PHASE_WIDTH      = fcd_pkg::PHASE_WIDTH_DEF,
   parameter int unsigned TABLE_ADDR_WIDTH = fcd_pkg::TABLE_ADDR_WIDTH_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   input  logic signed [SAMPLE_WIDTH-1:0]                in_real,
   input  logic signed [SAMPLE_WIDTH-1:0]                in_imag,
   input  logic                                          sof,
   input  logic [PHASE_WIDTH-1:0]                        phase_step,
   input  logic [PHASE_WIDTH-1:0]                        start_phase,
   input  logic [fcd_pkg::COUNT_W-1:0]                   frame_length,
   input  fcd_pkg::fcd_queue_status_type                 q_status,
   output logic                                          push,
   output logic [TABLE_ADDR_WIDTH+2*SAMPLE_WIDTH:0]      item
);
   import fcd_pkg::*;

   logic [PHASE_WIDTH-1:0] phase_ff, phase_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [PHASE_WIDTH-1:0] phase_now;
   logic                   last;

   assign req_tready = !q_status.full;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      phase_now = sof ? start_phase : phase_ff;
      phase_in  = phase_now + phase_step;
      if (sof) begin
         count_in = COUNT_W'(1);
      end else if (count_ff == COUNT_MAX) begin
         count_in = count_ff;
      end else begin
         count_in = count_ff + COUNT_W'(1);
      end
      last = (frame_length != '0) && (count_in == frame_length);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         count_ff <= '0;
      end else if (push) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   // {last, imag, real, table address}
   assign item = {last, in_imag, in_real,
                  phase_now[PHASE_WIDTH-1 -: TABLE_ADDR_WIDTH]};

endmodule

>>> rtl/fcd_queue.sv
// Small register FIFO decoupling the front end from the datapath.
// Depends on fcd_pkg (status struct).
module fcd_queue #(
   parameter int unsigned DATA_W = 43,
   parameter int unsigned DEPTH  = fcd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [DATA_W-1:0]             wr_data,
   input  logic                          pop,
   output logic [DATA_W-1:0]             rd_data,
   output fcd_pkg::fcd_queue_status_type status
);
   import fcd_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;

   always_comb begin
      wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      case ({push, pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_in;
         if (pop)  rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data      = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

>>> rtl/fcd_back.sv
// Datapath: table lookup, gain scaling, complex multiply, round and saturate.
// Depends on fcd_pkg and fcd_sine_rom; drains fcd_queue.
module fcd_back #(
   parameter int unsigned SAMPLE_WIDTH     = fcd_pkg::SAMPLE_WIDTH_DEF,
   parameter int unsigned TABLE_ADDR_WIDTH = fcd_pkg::TABLE_ADDR_WIDTH_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  fcd_pkg::fcd_queue_status_type            q_status,
   input  logic [TABLE_ADDR_WIDTH+2*SAMPLE_WIDTH:0] item,
   input  logic [fcd_pkg::GAIN_W-1:0]               gain,
   output fcd_pkg::fcd_back_status_type             status,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic signed [SAMPLE_WIDTH-1:0]           out_real,
   output logic signed [SAMPLE_WIDTH-1:0]           out_imag,
   output logic                                     out_last
);
   import fcd_pkg::*;

   localparam int unsigned TAW   = TABLE_ADDR_WIDTH;
   localparam int unsigned IdxW  = TAW - 1;
   localparam int unsigned CoefW = 32;
   localparam int unsigned ProdW = SAMPLE_WIDTH + CoefW;
   localparam int unsigned SumW  = ProdW + 1;
   localparam logic [IdxW-1:0]        QuarterIdx = IdxW'(1) << (TAW - 2);
   localparam logic signed [SumW-1:0] RoundHalf  = SumW'(1) << 28;
   localparam logic signed [SumW-1:0] SatHi      = SumW'((1 << (SAMPLE_WIDTH - 1)) - 1);
   localparam logic signed [SumW-1:0] SatLo      = -SatHi - SumW'(1);

   logic adv, pop;

   // stage 0: table addressing from queue head
   logic [TAW-1:0]                 q_addr;
   logic signed [SAMPLE_WIDTH-1:0] q_real, q_imag;
   logic                           q_last;
   logic [1:0]                     quad_s, quad_c;
   logic [IdxW-1:0]                r_ext, idx_s, idx_c;
   logic [TABLE_W-1:0]             rom_c, rom_s;

   assign q_addr = item[TAW-1:0];
   assign q_real = item[TAW +: SAMPLE_WIDTH];
   assign q_imag = item[TAW+SAMPLE_WIDTH +: SAMPLE_WIDTH];
   assign q_last = item[TAW+2*SAMPLE_WIDTH];

   always_comb begin
      quad_s = q_addr[TAW-1 -: 2];
      quad_c = quad_s + 2'd1;               // cos is sin a quarter turn on
      r_ext  = {1'b0, q_addr[TAW-3:0]};
      idx_s  = quad_s[0] ? QuarterIdx - r_ext : r_ext;
      idx_c  = quad_c[0] ? QuarterIdx - r_ext : r_ext;
   end

   fcd_sine_rom #(
      .TABLE_ADDR_WIDTH(TABLE_ADDR_WIDTH)
   ) u_rom (
      .clock  (clock),
      .en     (adv),
      .addr_a (idx_c),
      .addr_b (idx_s),
      .data_a (rom_c),
      .data_b (rom_s)
   );

   // stage registers
   logic                           s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic                           s1_last_ff, s2_last_ff, s3_last_ff, s4_last_ff;
   logic                           s1_cneg_ff, s1_sneg_ff;
   logic signed [SAMPLE_WIDTH-1:0] s1_real_ff, s1_imag_ff, s2_real_ff, s2_imag_ff;
   logic signed [CoefW-1:0]        s2_gc_ff, s2_gs_ff, gc_in, gs_in;
   logic signed [ProdW-1:0]        s3_ac_ff, s3_bs_ff, s3_as_ff, s3_bc_ff;
   logic signed [SumW-1:0]         s4_re_ff, s4_im_ff;
   logic                           rsp_valid_ff, rsp_last_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_real_ff, rsp_imag_ff, rsp_real_in, rsp_imag_in;

   logic signed [TABLE_W+1:0]      cos_v, sin_v;
   logic signed [TABLE_W+18:0]     gc_full, gs_full;

   assign adv = !rsp_valid_ff || rsp_tready;
   assign pop = adv && !q_status.empty;
   assign status.pop = pop;
   assign status.adv = adv;

   // stage 2: gain times signed cos / sin; |gain*32767| < 2^31
   always_comb begin
      cos_v   = s1_cneg_ff ? -$signed({2'b00, rom_c}) : $signed({2'b00, rom_c});
      sin_v   = s1_sneg_ff ? -$signed({2'b00, rom_s}) : $signed({2'b00, rom_s});
      gc_full = $signed({1'b0, gain}) * cos_v;
      gs_full = $signed({1'b0, gain}) * sin_v;
      gc_in   = gc_full[CoefW-1:0];
      gs_in   = gs_full[CoefW-1:0];
   end

   function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(
      input logic signed [SumW-1:0] v);
      logic signed [SumW-1:0] q;
      q = (v + RoundHalf) >>> 29;
      if (q > SatHi) begin
         q = SatHi;
      end else if (q < SatLo) begin
         q = SatLo;
      end
      return q[SAMPLE_WIDTH-1:0];
   endfunction

   assign rsp_real_in = round_sat(s4_re_ff);
   assign rsp_imag_in = round_sat(s4_im_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= pop;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_cneg_ff  <= quad_c[1];
         s1_sneg_ff  <= quad_s[1];
         s1_real_ff  <= q_real;
         s1_imag_ff  <= q_imag;
         s1_last_ff  <= q_last;

         s2_gc_ff    <= gc_in;
         s2_gs_ff    <= gs_in;
         s2_real_ff  <= s1_real_ff;
         s2_imag_ff  <= s1_imag_ff;
         s2_last_ff  <= s1_last_ff;

         s3_ac_ff    <= s2_real_ff * s2_gc_ff;
         s3_bs_ff    <= s2_imag_ff * s2_gs_ff;
         s3_as_ff    <= s2_real_ff * s2_gs_ff;
         s3_bc_ff    <= s2_imag_ff * s2_gc_ff;
         s3_last_ff  <= s2_last_ff;

         s4_re_ff    <= SumW'(s3_ac_ff) - SumW'(s3_bs_ff);
         s4_im_ff    <= SumW'(s3_as_ff) + SumW'(s3_bc_ff);
         s4_last_ff  <= s3_last_ff;

         rsp_real_ff <= rsp_real_in;
         rsp_imag_ff <= rsp_imag_in;
         rsp_last_ff <= s4_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign out_real   = rsp_real_ff;
   assign out_imag   = rsp_imag_ff;
   assign out_last   = rsp_last_ff;

endmodule

>>> rtl/frame_cfo_derotator_unit.sv
// Top level of the frame CFO derotator: register file, front end, queue, datapath.
// Depends on fcd_pkg, fcd_front, fcd_queue, fcd_back (and fcd_sine_rom below it).
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  req     | in  | req_tvalid/tready    | tdata {in_imag, in_real}, tuser start of frame
//  rsp     | out | rsp_tvalid/tready    | tdata {out_imag, out_real}, tlast frame_last
//  csr     | in  | csr_wr_en            | csr_index, csr_wdata (write only)
//
//  Throughput: one request per cycle sustained while rsp_tready is high; each request
//  takes one pass through the dual-port sine ROM and the multiplier pipeline, both of
//  which issue every cycle. Path to rsp_tvalid: queue, ROM, stage and result registers.
//  Reset (synchronous) clears the phase, frame counter, queue and all valids, and
//  loads the register reset values; no clearing pass is needed.
//  A stalled rsp side freezes the datapath; the queue keeps taking requests until full.
module frame_cfo_derotator_unit #(
   parameter int unsigned SAMPLE_WIDTH     = fcd_pkg::SAMPLE_WIDTH_DEF,
   parameter int unsigned PHASE_WIDTH      = fcd_pkg::PHASE_WIDTH_DEF,
   parameter int unsigned TABLE_ADDR_WIDTH = fcd_pkg::TABLE_ADDR_WIDTH_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // request side
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]      req_tdata,  // in_real, in_imag
   input  logic                                     req_tuser,  // start of frame
   // result side
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]      rsp_tdata,  // out_real, out_imag
   output logic                                     rsp_tlast,  // frame_last
   // register write port
   input  logic                                     csr_wr_en,
   input  fcd_pkg::fcd_csr_index_type               csr_index,
   input  logic [fcd_pkg::CSR_DATA_W-1:0]           csr_wdata
);
   import fcd_pkg::*;

   localparam int unsigned TdataW = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int unsigned ItemW  = TABLE_ADDR_WIDTH + 2 * SAMPLE_WIDTH + 1;

   // ---------------------------------------------------------------- registers
   logic [CSR_DATA_W-1:0] phase_step_ff;
   logic [CSR_DATA_W-1:0] start_phase_ff;
   logic [GAIN_W-1:0]     gain_ff;
   logic [COUNT_W-1:0]    frame_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff   <= '0;
         start_phase_ff  <= '0;
         gain_ff         <= GAIN_RESET;
         frame_length_ff <= FRAME_LEN_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PHASE_STEP:   phase_step_ff   <= csr_wdata;
            CSR_START_PHASE:  start_phase_ff  <= csr_wdata;
            CSR_GAIN:         gain_ff         <= csr_wdata[GAIN_W-1:0];
            CSR_FRAME_LENGTH: frame_length_ff <= csr_wdata[COUNT_W-1:0];
            default:          ;
         endcase
      end
   end

   // ---------------------------------------------------------------- front end
   fcd_queue_status_type q_status;
   fcd_back_status_type  b_status;
   logic                 push;
   logic [ItemW-1:0]     front_item;
   logic [ItemW-1:0]     head_item;

   fcd_front #(
      .SAMPLE_WIDTH     (SAMPLE_WIDTH),
      .PHASE_WIDTH      (PHASE_WIDTH),
      .TABLE_ADDR_WIDTH (TABLE_ADDR_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .in_real      (req_tdata[SAMPLE_WIDTH-1:0]),
      .in_imag      (req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
      .sof          (req_tuser),
      .phase_step   (phase_step_ff[PHASE_WIDTH-1:0]),
      .start_phase  (start_phase_ff[PHASE_WIDTH-1:0]),
      .frame_length (frame_length_ff),
      .q_status     (q_status),
      .push         (push),
      .item         (front_item)
   );

   // ---------------------------------------------------------------- queue
   fcd_queue #(
      .DATA_W (ItemW),
      .DEPTH  (QUEUE_DEPTH_DEF)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (front_item),
      .pop     (b_status.pop),
      .rd_data (head_item),
      .status  (q_status)
   );

   // ---------------------------------------------------------------- datapath
   logic signed [SAMPLE_WIDTH-1:0] out_real;
   logic signed [SAMPLE_WIDTH-1:0] out_imag;

   fcd_back #(
      .SAMPLE_WIDTH     (SAMPLE_WIDTH),
      .TABLE_ADDR_WIDTH (TABLE_ADDR_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .item       (head_item),
      .gain       (gain_ff),
      .status     (b_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .out_real   (out_real),
      .out_imag   (out_imag),
      .out_last   (rsp_tlast)
   );

   // pad to whole bytes with zeros
   assign rsp_tdata = TdataW'({out_imag, out_real});

   // ---------------------------------------------------------------- checks
   a_full_blocks_req: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !req_tready)
      else $error("request taken while queue full");

   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      b_status.pop |-> !q_status.empty)
      else $error("datapath popped an empty queue");

   a_no_pop_on_stall: assert property (@(posedge clock) disable iff (reset)
      !b_status.adv |-> !b_status.pop)
      else $error("queue popped while datapath stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (q_status.empty && !rsp_tvalid))
      else $error("queue or result valid not cleared by reset");

endmodule

>>> verif/frame_cfo_derotator_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for frame_cfo_derotator_unit: random and directed IQ streams,
// predicted in-bench, compared on the rsp channel. Depends on fcd_pkg and the RTL.
module frame_cfo_derotator_unit_test;
   import fcd_pkg::*;

   localparam int unsigned SW          = 16;
   localparam int unsigned QUARTER     = 256;            // quarter wave of a 1024-entry table
   localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
   localparam int unsigned SETTLE_CYCLES = 12;           // margin for the pipeline to empty in drain()

   typedef struct {
      logic [SW-1:0] re;
      logic [SW-1:0] im;
      logic          start;
   } iq_request_type;

   typedef struct {
      logic [SW-1:0] re;
      logic [SW-1:0] im;
      logic          last;
   } iq_result_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // DUT ports; the inputs are known from time zero
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [2*SW-1:0]         req_tdata  = '0;
   logic                    req_tuser  = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [2*SW-1:0]         rsp_tdata;
   logic                    rsp_tlast;
   logic                    csr_wr_en  = 1'b0;
   fcd_csr_index_type       csr_index  = CSR_PHASE_STEP;
   logic [CSR_DATA_W-1:0]   csr_wdata  = '0;

   frame_cfo_derotator_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // in_real, in_imag
      .req_tuser  (req_tuser),   // start of frame
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // out_real, out_imag
      .rsp_tlast  (rsp_tlast),   // frame_last
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // ---------------------------------------------------------------------------------
   // Mixer predictor: own copy of the registers, phase and frame counter
   // ---------------------------------------------------------------------------------
   logic [31:0] step_q      = '0;
   logic [31:0] start_q     = '0;
   logic [15:0] gain_q      = GAIN_RESET;
   logic [15:0] frame_len_q = FRAME_LEN_RESET;
   logic [31:0] nco_phase   = '0;
   logic [15:0] frame_count = '0;

   int quarter_wave [0:QUARTER];

   iq_request_type pending_reqs [$];
   iq_result_type  expected_iq  [$];
   int             mismatch_count = 0;
   bit             idle_on = 1'b0;   // random gaps on both sides

   // Taylor series sine, Q30 internally, rounded to Q1.15 magnitude
   function automatic int taylor_q15(input int unsigned k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      longint          r;
      int unsigned     n;
      x    = k;
      x    = (x * PI_HALF_Q30) >> 8;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (n = 1; n <= 10; n++) begin
         term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      r = (acc + 64'sd16384) >>> 15;
      if (r > 32767) begin
         r = 32767;
      end
      return int'(r);
   endfunction

   function automatic int sine_at(input logic [9:0] k);
      int mag;
      mag = k[8] ? quarter_wave[QUARTER - k[7:0]] : quarter_wave[k[7:0]];
      return k[9] ? -mag : mag;
   endfunction

   // Q29 product back to Q1.15: round half up, floor shift, clamp
   function automatic logic [SW-1:0] round_clamp(input longint p);
      longint q;
      q = (p + (64'sd1 <<< 28)) >>> 29;
      if (q > 32767) begin
         q = 32767;
      end else if (q < -32768) begin
         q = -32768;
      end
      return q[SW-1:0];
   endfunction

   // advances phase and frame counter for one accepted request
   function automatic iq_result_type derotate(input iq_request_type s);
      logic [31:0]   ph;
      logic [9:0]    addr;
      longint        a;
      longint        b;
      longint        gc;
      longint        gs;
      iq_result_type r;
      if (s.start) begin
         ph          = start_q;
         frame_count = 16'd1;
      end else begin
         ph = nco_phase;
         if (frame_count != 16'hFFFF) begin
            frame_count = frame_count + 16'd1;
         end
      end
      nco_phase = ph + step_q;
      addr = ph[31:22];
      gc   = longint'(gain_q) * sine_at(10'(addr + 10'd256));
      gs   = longint'(gain_q) * sine_at(addr);
      a    = longint'($signed(s.re));
      b    = longint'($signed(s.im));
      r.re   = round_clamp(a * gc - b * gs);
      r.im   = round_clamp(a * gs + b * gc);
      r.last = (frame_len_q != 16'd0) && (frame_count == frame_len_q);
      return r;
   endfunction

   // ---------------------------------------------------------------------------------
   // Request driver: pops pending requests, predicts on each accepted one
   // ---------------------------------------------------------------------------------
   int unsigned send_gap = 0;

   always @(posedge clock) begin
      iq_request_type nxt;
      iq_request_type took;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            took.re    = req_tdata[SW-1:0];
            took.im    = req_tdata[2*SW-1:SW];
            took.start = req_tuser;
            expected_iq.push_back(derotate(took));
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap   = send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               nxt = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {nxt.im, nxt.re};
               req_tuser  <= nxt.start;
               if (idle_on && $urandom_range(0, 11) == 0) begin
                  send_gap = $urandom_range(1, 19);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Result monitor: random back-pressure, field-by-field compare
   // ---------------------------------------------------------------------------------
   int unsigned recv_gap = 0;

   always @(posedge clock) begin
      iq_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_iq.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result, expected none, got re %0d im %0d last %0b",
                        $time, $signed(rsp_tdata[SW-1:0]), $signed(rsp_tdata[2*SW-1:SW]),
                        rsp_tlast);
            end else begin
               want = expected_iq.pop_front();
               if (rsp_tdata[SW-1:0] !== want.re) begin
                  mismatch_count++;
                  $display("%0t: out_real expected %0d got %0d", $time,
                           $signed(want.re), $signed(rsp_tdata[SW-1:0]));
               end
               if (rsp_tdata[2*SW-1:SW] !== want.im) begin
                  mismatch_count++;
                  $display("%0t: out_imag expected %0d got %0d", $time,
                           $signed(want.im), $signed(rsp_tdata[2*SW-1:SW]));
               end
               if (rsp_tlast !== want.last) begin
                  mismatch_count++;
                  $display("%0t: frame_last expected %0b got %0b", $time,
                           want.last, rsp_tlast);
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap   = recv_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 11) == 0) begin
               recv_gap = $urandom_range(1, 19);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------
   function automatic void push_iq(input logic [SW-1:0] re, input logic [SW-1:0] im,
                                   input logic start);
      iq_request_type s;
      s.re    = re;
      s.im    = im;
      s.start = start;
      pending_reqs.push_back(s);
   endfunction

   // full-scale random most of the time, rails and near-zero now and then
   function automatic logic [SW-1:0] pick_iq();
      case ($urandom_range(0, 9))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'($urandom_range(0, 31)) - 16'd16;
         default: return 16'($urandom);
      endcase
   endfunction

   // register write; model copy taken at once since the block is idle
   task automatic write_reg(input fcd_csr_index_type idx, input logic [31:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_PHASE_STEP:   step_q      = val;
         CSR_START_PHASE:  start_q     = val;
         CSR_GAIN:         gain_q      = val[15:0];
         CSR_FRAME_LENGTH: frame_len_q = val[15:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic write_all(input logic [31:0] step, input logic [31:0] ph0,
                            input logic [15:0] g, input logic [15:0] len);
      write_reg(CSR_PHASE_STEP, step);
      write_reg(CSR_START_PHASE, ph0);
      write_reg(CSR_GAIN, {16'd0, g});
      write_reg(CSR_FRAME_LENGTH, {16'd0, len});
   endtask

   // every request sent, every result back, then let the pipeline empty
   task automatic drain();
      do begin
         @(negedge clock);
      end while (pending_reqs.size() != 0 || req_tvalid || expected_iq.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------
   initial begin
      int          p;
      int          i;
      int          len;
      logic [31:0] step;
      logic [31:0] ph0;
      logic [15:0] g;
      logic [15:0] flen;

      for (i = 0; i <= QUARTER; i++) begin
         quarter_wave[i] = taylor_q15(i);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: full gain, frames of three, samples ahead of any frame start
      write_all(32'h0400_0000, 32'hC000_0000, 16'hFFFF, 16'd3);
      @(negedge clock);
      idle_on = 1'b1;
      push_iq(16'h7FFF, 16'h0000, 1'b0);
      push_iq(16'h0000, 16'h7FFF, 1'b0);
      push_iq(16'h8000, 16'h8000, 1'b0);   // third sample flagged though no frame began
      push_iq(16'h8000, 16'h7FFF, 1'b1);
      push_iq(16'h7FFF, 16'h8000, 1'b0);
      push_iq(16'h7FFF, 16'h7FFF, 1'b0);
      push_iq(16'h0000, 16'h0000, 1'b0);   // past the frame end: no flag
      push_iq(16'hFFFF, 16'hFFFF, 1'b1);
      push_iq(16'h0001, 16'h0001, 1'b1);   // back-to-back frame starts
      push_iq(16'h4000, 16'hC000, 1'b0);
      push_iq(16'h8000, 16'h0000, 1'b0);
      drain();

      // zero gain and zero frame length: flag never set
      write_all(32'h8000_0000, 32'h0000_0000, 16'd0, 16'd0);
      @(negedge clock);
      push_iq(16'h7FFF, 16'h7FFF, 1'b1);
      push_iq(16'h8000, 16'h8000, 1'b0);
      push_iq(16'h3039, 16'hCFC7, 1'b0);
      push_iq(16'hFFFF, 16'h0001, 1'b0);
      drain();

      // one-sample frames, step of minus one LSB
      write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd16384, 16'd1);
      @(negedge clock);
      push_iq(16'h1234, 16'hEDCC, 1'b1);
      push_iq(16'h7FFF, 16'h8000, 1'b0);
      push_iq(16'h5555, 16'hAAAA, 1'b1);
      push_iq(16'hAAAA, 16'h5555, 1'b1);
      drain();

      // random phases, mostly well-formed frames; the last one runs without gaps
      for (p = 0; p < 8; p++) begin
         case (p % 4)
            0:       step = 32'd0;
            1:       step = 32'hFFFF_FFFF;
            2:       step = $urandom;
            default: step = $urandom_range(0, 32'h0100_0000);
         endcase
         case (p % 3)
            0:       ph0 = 32'd0;
            1:       ph0 = 32'hFFFF_FFFF;
            default: ph0 = $urandom;
         endcase
         case (p % 4)
            0:       g = 16'($urandom);
            1:       g = 16'hFFFF;
            2:       g = 16'd16384;
            default: g = 16'($urandom_range(4096, 24576));
         endcase
         case (p % 4)
            0:       flen = 16'($urandom_range(1, 40));
            1:       flen = 16'd1;
            2:       flen = 16'($urandom_range(2, 12));
            default: flen = (p == 3) ? 16'd0 : 16'hFFFF;
         endcase
         write_all(step, ph0, g, flen);
         @(negedge clock);
         idle_on = (p != 7);
         while (pending_reqs.size() < 200) begin
            if ($urandom_range(0, 9) < 8) begin
               len = (frame_len_q != 0 && frame_len_q <= 64) ? int'(frame_len_q)
                                                              : $urandom_range(1, 64);
               // occasionally a frame one short or one long
               case ($urandom_range(0, 5))
                  0:       len = len + 1;
                  1:       if (len > 1) len = len - 1;
                  default: ;
               endcase
               for (i = 0; i < len; i++) begin
                  push_iq(pick_iq(), pick_iq(), i == 0);
               end
            end else begin
               len = $urandom_range(1, 8);
               for (i = 0; i < len; i++) begin
                  push_iq(pick_iq(), pick_iq(), $urandom_range(0, 3) == 0);
               end
            end
         end
         drain();
      end

      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #10ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule
